// ===== rtl/rps_pkg.sv =====
// Shared types and codes for the repeat phase sequencer.
`default_nettype none

package rps_pkg;

	// Command codes carried in the mode field.
	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_TICK   = 2'd1;
	localparam logic [1:0] CMD_PAUSE  = 2'd2;
	localparam logic [1:0] CMD_RESUME = 2'd3;

	// Phase codes.
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_COND = 2'd1;
	localparam logic [1:0] PH_EXEC = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	// Event codes.
	localparam logic [2:0] EV_NONE   = 3'd0;
	localparam logic [2:0] EV_COND   = 3'd1;
	localparam logic [2:0] EV_OK     = 3'd2;
	localparam logic [2:0] EV_ERR    = 3'd3;
	localparam logic [2:0] EV_PAUSE  = 3'd4;
	localparam logic [2:0] EV_RESUME = 3'd5;

	// Condition modes.
	localparam logic [1:0] CMODE_NONE = 2'd0;
	localparam logic [1:0] CMODE_TIME = 2'd1;
	localparam logic [1:0] CMODE_TEMP = 2'd2;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_WIDTH = 3;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_TOTAL_REPEATS  = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_CONDITION_MODE = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_COND_TIME      = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_TARGET_TEMP    = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_EXEC_TIME      = 3'd4;

	localparam int unsigned CFG_DATA_WIDTH = 16;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] temperature;
		logic               temp_sensor_present;
		logic               pressure_violation;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic        paused_flag;
		logic [7:0]  repeat_index;
		logic [15:0] elapsed_sec;
		logic [7:0]  done_count;
		logic [7:0]  error_count;
		logic [2:0]  event_res;
		logic        run_finished;
		logic        run_ok;
	} res_t;

	typedef struct packed {
		logic [7:0]         total_repeats;
		logic [1:0]         condition_mode;
		logic [15:0]        condition_time_limit;
		logic signed [15:0] target_temperature;
		logic [15:0]        execution_time_limit;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/rps_step.sv =====
// Next-state and event logic for one command of the repeat phase sequencer.
`default_nettype none

module rps_step #(
	parameter int unsigned REPEAT_WIDTH = 8,
	parameter int unsigned TIME_WIDTH   = 16
) (
	input  var rps_pkg::cfg_t           cfg,
	input  var rps_pkg::cmd_t           cmd,
	input  wire  [1:0]                  phase,
	input  wire                         paused,
	input  wire  [REPEAT_WIDTH-1:0]     rep,
	input  wire  [TIME_WIDTH-1:0]       elapsed,
	input  wire  [REPEAT_WIDTH-1:0]     succ,
	input  wire  [REPEAT_WIDTH-1:0]     fail,
	output logic [1:0]                  phase_nxt,
	output logic                        paused_nxt,
	output logic [REPEAT_WIDTH-1:0]     rep_nxt,
	output logic [TIME_WIDTH-1:0]       elapsed_nxt,
	output logic [REPEAT_WIDTH-1:0]     succ_nxt,
	output logic [REPEAT_WIDTH-1:0]     fail_nxt,
	output logic [2:0]                  event_nxt
);

	localparam int unsigned RCW = (REPEAT_WIDTH > 8) ? REPEAT_WIDTH : 8;
	localparam int unsigned TCW = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;
	localparam logic [REPEAT_WIDTH-1:0] REP_MAX = {REPEAT_WIDTH{1'b1}};
	localparam logic [REPEAT_WIDTH-1:0] REP_ONE = REPEAT_WIDTH'(1);
	localparam logic [TIME_WIDTH-1:0]   TIME_MAX = {TIME_WIDTH{1'b1}};
	localparam logic [TIME_WIDTH-1:0]   TIME_ONE = TIME_WIDTH'(1);

	logic [RCW-1:0]          total_ext;
	logic [RCW-1:0]          total_clip;
	logic                    running;
	logic                    cond_enabled;
	logic [TIME_WIDTH-1:0]   el_inc;
	logic [REPEAT_WIDTH-1:0] rep_inc;
	logic [REPEAT_WIDTH-1:0] succ_inc;
	logic [REPEAT_WIDTH-1:0] fail_inc;
	logic [1:0]              first_phase;
	logic [1:0]              after_phase;
	logic                    cond_met;
	logic                    exec_limit;

	always_comb begin
		total_ext  = RCW'(cfg.total_repeats);
		// The repeat count cannot exceed what the repeat counter can hold.
		total_clip = (total_ext > RCW'(REP_MAX)) ? RCW'(REP_MAX) : total_ext;

		running = (phase == rps_pkg::PH_COND) || (phase == rps_pkg::PH_EXEC);
		cond_enabled = ((cfg.condition_mode == rps_pkg::CMODE_TIME) ||
			(cfg.condition_mode == rps_pkg::CMODE_TEMP)) &&
			(cfg.condition_time_limit != 16'd0);

		el_inc   = (elapsed == TIME_MAX) ? TIME_MAX : elapsed + TIME_ONE;
		rep_inc  = (rep == REP_MAX) ? REP_MAX : rep + REP_ONE;
		succ_inc = (succ == REP_MAX) ? REP_MAX : succ + REP_ONE;
		fail_inc = (fail == REP_MAX) ? REP_MAX : fail + REP_ONE;

		// Phase that a new repeat opens with, at index zero and after the current one.
		if (total_clip == '0) begin
			first_phase = rps_pkg::PH_DONE;
		end else if (cond_enabled) begin
			first_phase = rps_pkg::PH_COND;
		end else begin
			first_phase = rps_pkg::PH_EXEC;
		end
		if (RCW'(rep_inc) >= total_clip) begin
			after_phase = rps_pkg::PH_DONE;
		end else if (cond_enabled) begin
			after_phase = rps_pkg::PH_COND;
		end else begin
			after_phase = rps_pkg::PH_EXEC;
		end

		cond_met = (TCW'(el_inc) >= TCW'(cfg.condition_time_limit)) ||
			((cfg.condition_mode == rps_pkg::CMODE_TEMP) && cmd.temp_sensor_present &&
			($signed(cmd.temperature) <= $signed(cfg.target_temperature)));
		exec_limit = TCW'(el_inc) >= TCW'(cfg.execution_time_limit);

		phase_nxt   = phase;
		paused_nxt  = paused;
		rep_nxt     = rep;
		elapsed_nxt = elapsed;
		succ_nxt    = succ;
		fail_nxt    = fail;
		event_nxt   = rps_pkg::EV_NONE;

		unique case (cmd.mode)
			rps_pkg::CMD_START: begin
				rep_nxt     = '0;
				succ_nxt    = '0;
				fail_nxt    = '0;
				paused_nxt  = 1'b0;
				elapsed_nxt = '0;
				phase_nxt   = first_phase;
			end
			rps_pkg::CMD_TICK: begin
				if (running && !paused) begin
					elapsed_nxt = el_inc;
					if (phase == rps_pkg::PH_COND) begin
						if (cond_met) begin
							event_nxt   = rps_pkg::EV_COND;
							phase_nxt   = rps_pkg::PH_EXEC;
							elapsed_nxt = '0;
						end
					end else if (cmd.pressure_violation) begin
						// A violation wins over the time limit on the same tick.
						event_nxt   = rps_pkg::EV_ERR;
						fail_nxt    = fail_inc;
						rep_nxt     = rep_inc;
						elapsed_nxt = '0;
						phase_nxt   = after_phase;
					end else if (exec_limit) begin
						event_nxt   = rps_pkg::EV_OK;
						succ_nxt    = succ_inc;
						rep_nxt     = rep_inc;
						elapsed_nxt = '0;
						phase_nxt   = after_phase;
					end
				end
			end
			rps_pkg::CMD_PAUSE: begin
				if (running && !paused) begin
					paused_nxt = 1'b1;
					event_nxt  = rps_pkg::EV_PAUSE;
				end
			end
			rps_pkg::CMD_RESUME: begin
				if (paused) begin
					paused_nxt = 1'b0;
					event_nxt  = rps_pkg::EV_RESUME;
				end
			end
			default: begin
				event_nxt = rps_pkg::EV_NONE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/repeat_phase_sequencer.sv =====
// Top level of the repeat phase sequencer: handshakes, registers and state.
// Each item passes through the input register and then the output register.
// Throughput: one item per cycle unless stalled; state is updated in the same cycle
// that an item leaves the input register, so the next item sees it at once.
// Reset: arst_n clears the state to idle with all counters zero and loads the
// register reset values; no item is held in either register.
`default_nettype none

module repeat_phase_sequencer #(
	parameter int unsigned REPEAT_WIDTH = 8,
	parameter int unsigned TIME_WIDTH   = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cmd_valid,
	output logic                                 cmd_stall,
	input  var rps_pkg::cmd_t                    cmd,
	output logic                                 res_valid,
	input  wire                                  res_stall,
	output rps_pkg::res_t                        res,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [rps_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
	input  wire  [rps_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

	rps_pkg::cfg_t           cfg_q;
	rps_pkg::cmd_t           cmd_s1;
	logic                    valid_s1;
	rps_pkg::res_t           res_s2;
	logic                    valid_s2;
	logic                    advance_s2;
	logic                    fire_s1;

	logic [1:0]              phase_q;
	logic                    paused_q;
	logic [REPEAT_WIDTH-1:0] rep_q;
	logic [TIME_WIDTH-1:0]   elapsed_q;
	logic [REPEAT_WIDTH-1:0] succ_q;
	logic [REPEAT_WIDTH-1:0] fail_q;

	logic [1:0]              phase_nxt;
	logic                    paused_nxt;
	logic [REPEAT_WIDTH-1:0] rep_nxt;
	logic [TIME_WIDTH-1:0]   elapsed_nxt;
	logic [REPEAT_WIDTH-1:0] succ_nxt;
	logic [REPEAT_WIDTH-1:0] fail_nxt;
	logic [2:0]              event_nxt;

	assign cfg_ready  = 1'b1;
	assign advance_s2 = !valid_s2 || !res_stall;
	assign fire_s1    = valid_s1 && advance_s2;
	assign cmd_stall  = valid_s1 && !advance_s2;
	assign res_valid  = valid_s2;
	assign res        = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.total_repeats        <= 8'd1;
			cfg_q.condition_mode       <= rps_pkg::CMODE_NONE;
			cfg_q.condition_time_limit <= '0;
			cfg_q.target_temperature   <= '0;
			cfg_q.execution_time_limit <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rps_pkg::REG_TOTAL_REPEATS:  cfg_q.total_repeats <= cfg_data[7:0];
				rps_pkg::REG_CONDITION_MODE: cfg_q.condition_mode <= cfg_data[1:0];
				rps_pkg::REG_COND_TIME:      cfg_q.condition_time_limit <= cfg_data;
				rps_pkg::REG_TARGET_TEMP:    cfg_q.target_temperature <= $signed(cfg_data);
				rps_pkg::REG_EXEC_TIME:      cfg_q.execution_time_limit <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	rps_step #(
		.REPEAT_WIDTH (REPEAT_WIDTH),
		.TIME_WIDTH   (TIME_WIDTH)
	) u_step (
		.cfg         (cfg_q),
		.cmd         (cmd_s1),
		.phase       (phase_q),
		.paused      (paused_q),
		.rep         (rep_q),
		.elapsed     (elapsed_q),
		.succ        (succ_q),
		.fail        (fail_q),
		.phase_nxt   (phase_nxt),
		.paused_nxt  (paused_nxt),
		.rep_nxt     (rep_nxt),
		.elapsed_nxt (elapsed_nxt),
		.succ_nxt    (succ_nxt),
		.fail_nxt    (fail_nxt),
		.event_nxt   (event_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= rps_pkg::PH_IDLE;
			paused_q  <= 1'b0;
			rep_q     <= '0;
			elapsed_q <= '0;
			succ_q    <= '0;
			fail_q    <= '0;
		end else if (fire_s1) begin
			phase_q   <= phase_nxt;
			paused_q  <= paused_nxt;
			rep_q     <= rep_nxt;
			elapsed_q <= elapsed_nxt;
			succ_q    <= succ_nxt;
			fail_q    <= fail_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_s2.phase        <= phase_nxt;
			res_s2.paused_flag  <= paused_nxt;
			res_s2.repeat_index <= 8'(rep_nxt);
			res_s2.elapsed_sec  <= 16'(elapsed_nxt);
			res_s2.done_count   <= 8'(succ_nxt);
			res_s2.error_count  <= 8'(fail_nxt);
			res_s2.event_res    <= event_nxt;
			res_s2.run_finished <= (phase_nxt == rps_pkg::PH_DONE);
			res_s2.run_ok       <= (phase_nxt == rps_pkg::PH_DONE) && (fail_nxt == '0);
		end
	end

endmodule

`default_nettype wire

// ===== bench/tb_repeat_phase_sequencer.sv =====
// Self-checking testbench for the repeat phase sequencer: directed script, then random runs.
`default_nettype none

module tb_repeat_phase_sequencer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [rps_pkg::CFG_IDX_WIDTH-1:0] REG_UNUSED = 3'd7;
	localparam int HANG_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 4;
	localparam int PHASES       = 8;

	typedef struct {
		bit                                 wr;
		logic [rps_pkg::CFG_IDX_WIDTH-1:0]  idx;
		logic [rps_pkg::CFG_DATA_WIDTH-1:0] data;
		rps_pkg::cmd_t                      c;
		bit                                 typed;
		rps_pkg::res_t                      want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid, cmd_stall;
	rps_pkg::cmd_t cmd;
	logic res_valid, res_stall;
	rps_pkg::res_t res;
	logic cfg_valid, cfg_ready;
	logic [rps_pkg::CFG_IDX_WIDTH-1:0] cfg_index;
	logic [rps_pkg::CFG_DATA_WIDTH-1:0] cfg_data;

	// Shadow copy of the sequencer registers and state.
	rps_pkg::cfg_t regs;
	logic [1:0] ph;
	logic held;
	logic [7:0] rep_no, ok_no, bad_no;
	logic [15:0] secs;

	rps_pkg::res_t status_due[$];
	int errors = 0;
	int tx_count = 0;
	int rx_count = 0;
	int idle_cycles = 0;

	repeat_phase_sequencer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function void open_repeat();
		secs = '0;
		if (rep_no >= regs.total_repeats) begin
			ph = rps_pkg::PH_DONE;
		end else if ((regs.condition_mode == rps_pkg::CMODE_TIME
				|| regs.condition_mode == rps_pkg::CMODE_TEMP)
				&& regs.condition_time_limit != 16'd0) begin
			ph = rps_pkg::PH_COND;
		end else begin
			ph = rps_pkg::PH_EXEC;
		end
	endfunction

	function void close_repeat(bit good);
		if (good) begin
			if (ok_no != 8'hFF) ok_no = ok_no + 8'd1;
		end else begin
			if (bad_no != 8'hFF) bad_no = bad_no + 8'd1;
		end
		if (rep_no != 8'hFF) rep_no = rep_no + 8'd1;
		open_repeat();
	endfunction

	function void store_reg(logic [rps_pkg::CFG_IDX_WIDTH-1:0] idx,
			logic [rps_pkg::CFG_DATA_WIDTH-1:0] d);
		case (idx)
			rps_pkg::REG_TOTAL_REPEATS:  regs.total_repeats = d[7:0];
			rps_pkg::REG_CONDITION_MODE: regs.condition_mode = d[1:0];
			rps_pkg::REG_COND_TIME:      regs.condition_time_limit = d;
			rps_pkg::REG_TARGET_TEMP:    regs.target_temperature = d;
			rps_pkg::REG_EXEC_TIME:      regs.execution_time_limit = d;
			default: ;
		endcase
	endfunction

	function rps_pkg::res_t advance_sequencer(rps_pkg::cmd_t c);
		rps_pkg::res_t r;
		logic [2:0] ev;
		logic met;
		logic running;
		ev = rps_pkg::EV_NONE;
		running = (ph == rps_pkg::PH_COND || ph == rps_pkg::PH_EXEC);
		case (c.mode)
			rps_pkg::CMD_START: begin
				rep_no = '0;
				ok_no = '0;
				bad_no = '0;
				held = 1'b0;
				open_repeat();
			end
			rps_pkg::CMD_TICK: if (running && !held) begin
				if (secs != 16'hFFFF) secs = secs + 16'd1;
				if (ph == rps_pkg::PH_COND) begin
					met = (secs >= regs.condition_time_limit);
					// A present sensor at or below target ends the phase early.
					if (regs.condition_mode == rps_pkg::CMODE_TEMP && c.temp_sensor_present
							&& $signed(c.temperature) <= $signed(regs.target_temperature))
						met = 1'b1;
					if (met) begin
						ev = rps_pkg::EV_COND;
						ph = rps_pkg::PH_EXEC;
						secs = '0;
					end
				end else if (c.pressure_violation) begin
					ev = rps_pkg::EV_ERR;
					close_repeat(1'b0);
				end else if (secs >= regs.execution_time_limit) begin
					ev = rps_pkg::EV_OK;
					close_repeat(1'b1);
				end
			end
			rps_pkg::CMD_PAUSE: if (running && !held) begin
				held = 1'b1;
				ev = rps_pkg::EV_PAUSE;
			end
			rps_pkg::CMD_RESUME: if (held) begin
				held = 1'b0;
				ev = rps_pkg::EV_RESUME;
			end
		endcase
		r.phase = ph;
		r.paused_flag = held;
		r.repeat_index = rep_no;
		r.elapsed_sec = secs;
		r.done_count = ok_no;
		r.error_count = bad_no;
		r.event_res = ev;
		r.run_finished = (ph == rps_pkg::PH_DONE);
		r.run_ok = (ph == rps_pkg::PH_DONE && bad_no == 8'd0);
		return r;
	endfunction

	function automatic step_t reg_row(logic [rps_pkg::CFG_IDX_WIDTH-1:0] idx,
			logic [rps_pkg::CFG_DATA_WIDTH-1:0] d);
		step_t s;
		s.wr = 1'b1;
		s.idx = idx;
		s.data = d;
		s.c = '0;
		s.typed = 1'b0;
		s.want = '0;
		return s;
	endfunction

	function automatic step_t cmd_row(logic [1:0] m, logic [15:0] t, logic sensor, logic viol);
		step_t s;
		s.wr = 1'b0;
		s.idx = '0;
		s.data = '0;
		s.c.mode = m;
		s.c.temperature = t;
		s.c.temp_sensor_present = sensor;
		s.c.pressure_violation = viol;
		s.typed = 1'b0;
		s.want = '0;
		return s;
	endfunction

	// Row whose result can be written down directly: nothing paused, no errors, no elapsed time.
	function automatic step_t known_row(logic [1:0] m, logic [1:0] p, logic [7:0] rep,
			logic [7:0] done, logic [2:0] ev);
		step_t s;
		s = cmd_row(m, 16'd0, 1'b0, 1'b0);
		s.typed = 1'b1;
		s.want = '0;
		s.want.phase = p;
		s.want.repeat_index = rep;
		s.want.done_count = done;
		s.want.event_res = ev;
		s.want.run_finished = (p == rps_pkg::PH_DONE);
		s.want.run_ok = (p == rps_pkg::PH_DONE);
		return s;
	endfunction

	task automatic drain();
		cmd_valid <= 1'b0;
		while (status_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [rps_pkg::CFG_IDX_WIDTH-1:0] idx,
			logic [rps_pkg::CFG_DATA_WIDTH-1:0] d);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		store_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic issue(rps_pkg::cmd_t c, bit typed, rps_pkg::res_t want);
		int gap;
		rps_pkg::res_t predicted;
		tx_count++;
		gap = (tx_count % 200 < 30) ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall !== 1'b0) @(posedge clk);
		predicted = advance_sequencer(c);
		status_due.push_back(typed ? want : predicted);
		@(negedge clk);
	endtask

	task automatic flag(string what, logic [15:0] want, logic [15:0] got);
		$display("%0t: %s expected %0d got %0d", $time, what, want, got);
		errors++;
	endtask

	initial begin : collect_results
		int hold;
		rps_pkg::res_t want;
		res_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			rx_count++;
			hold = (rx_count % 170 < 25) ? 0 : $urandom_range(0, 7);
			if (hold != 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (res_valid !== 1'b1) @(posedge clk);
			if (status_due.size() == 0) begin
				$display("%0t: result with no item pending, got %p", $time, res);
				errors++;
			end else begin
				want = status_due.pop_front();
				if (res.phase !== want.phase)
					flag("phase", 16'(want.phase), 16'(res.phase));
				if (res.paused_flag !== want.paused_flag)
					flag("paused_flag", 16'(want.paused_flag), 16'(res.paused_flag));
				if (res.repeat_index !== want.repeat_index)
					flag("repeat_index", 16'(want.repeat_index), 16'(res.repeat_index));
				if (res.elapsed_sec !== want.elapsed_sec)
					flag("elapsed_sec", want.elapsed_sec, res.elapsed_sec);
				if (res.done_count !== want.done_count)
					flag("done_count", 16'(want.done_count), 16'(res.done_count));
				if (res.error_count !== want.error_count)
					flag("error_count", 16'(want.error_count), 16'(res.error_count));
				if (res.event_res !== want.event_res)
					flag("event_res", 16'(want.event_res), 16'(res.event_res));
				if (res.run_finished !== want.run_finished)
					flag("run_finished", 16'(want.run_finished), 16'(res.run_finished));
				if (res.run_ok !== want.run_ok)
					flag("run_ok", 16'(want.run_ok), 16'(res.run_ok));
			end
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && cmd_stall === 1'b0) || (res_valid === 1'b1 && !res_stall)
				|| (cfg_valid && cfg_ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == HANG_LIMIT) begin
			$display("tb_repeat_phase_sequencer NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		step_t script[$];
		rps_pkg::cmd_t c;
		int n_items;
		int pick;
		logic [7:0] tr;
		logic [1:0] cm;
		logic [15:0] ct, tt, et, junk, near;
		cmd_valid <= 1'b0;
		cmd <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		regs = '0;
		regs.total_repeats = 8'd1;
		ph = rps_pkg::PH_IDLE;
		held = 1'b0;
		rep_no = '0;
		ok_no = '0;
		bad_no = '0;
		secs = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values: one repeat, no condition phase, zero execution time.
		script.push_back(known_row(rps_pkg::CMD_TICK, rps_pkg::PH_IDLE, 8'd0, 8'd0,
			rps_pkg::EV_NONE));
		script.push_back(known_row(rps_pkg::CMD_PAUSE, rps_pkg::PH_IDLE, 8'd0, 8'd0,
			rps_pkg::EV_NONE));
		script.push_back(known_row(rps_pkg::CMD_RESUME, rps_pkg::PH_IDLE, 8'd0, 8'd0,
			rps_pkg::EV_NONE));
		script.push_back(known_row(rps_pkg::CMD_START, rps_pkg::PH_EXEC, 8'd0, 8'd0,
			rps_pkg::EV_NONE));
		script.push_back(known_row(rps_pkg::CMD_TICK, rps_pkg::PH_DONE, 8'd1, 8'd1,
			rps_pkg::EV_OK));
		script.push_back(known_row(rps_pkg::CMD_TICK, rps_pkg::PH_DONE, 8'd1, 8'd1,
			rps_pkg::EV_NONE));
		script.push_back(reg_row(rps_pkg::REG_TOTAL_REPEATS, 16'h0000));
		script.push_back(reg_row(REG_UNUSED, 16'hFFFF));
		script.push_back(known_row(rps_pkg::CMD_START, rps_pkg::PH_DONE, 8'd0, 8'd0,
			rps_pkg::EV_NONE));
		// Temperature condition with a time fallback; upper data bits must be dropped.
		script.push_back(reg_row(rps_pkg::REG_TOTAL_REPEATS, 16'hA502));
		script.push_back(reg_row(rps_pkg::REG_CONDITION_MODE, 16'hFFFE));
		script.push_back(reg_row(rps_pkg::REG_COND_TIME, 16'd3));
		script.push_back(reg_row(rps_pkg::REG_TARGET_TEMP, 16'hFF9C));
		script.push_back(reg_row(rps_pkg::REG_EXEC_TIME, 16'd2));
		script.push_back(cmd_row(rps_pkg::CMD_START, 16'd0, 1'b0, 1'b0));
		script.push_back(cmd_row(rps_pkg::CMD_TICK, 16'hFFCE, 1'b1, 1'b0));
		script.push_back(cmd_row(rps_pkg::CMD_TICK, 16'hFF9C, 1'b0, 1'b0));
		script.push_back(cmd_row(rps_pkg::CMD_TICK, 16'hFF9C, 1'b1, 1'b0));
		script.push_back(cmd_row(rps_pkg::CMD_PAUSE, 16'd0, 1'b0, 1'b0));
		script.push_back(cmd_row(rps_pkg::CMD_PAUSE, 16'd0, 1'b0, 1'b0));
		script.push_back(cmd_row(rps_pkg::CMD_TICK, 16'd0, 1'b0, 1'b1));
		script.push_back(cmd_row(rps_pkg::CMD_RESUME, 16'd0, 1'b0, 1'b0));
		script.push_back(cmd_row(rps_pkg::CMD_TICK, 16'd0, 1'b1, 1'b1));
		repeat (3) script.push_back(cmd_row(rps_pkg::CMD_TICK, 16'h7FFF, 1'b1, 1'b0));
		script.push_back(cmd_row(rps_pkg::CMD_TICK, 16'h7FFF, 1'b1, 1'b0));
		// Violation and time limit on the same tick.
		script.push_back(cmd_row(rps_pkg::CMD_TICK, 16'h7FFF, 1'b1, 1'b1));
		script.push_back(reg_row(rps_pkg::REG_CONDITION_MODE, 16'd3));
		script.push_back(cmd_row(rps_pkg::CMD_START, 16'd0, 1'b0, 1'b0));
		script.push_back(reg_row(rps_pkg::REG_CONDITION_MODE, {14'd0, rps_pkg::CMODE_TIME}));
		script.push_back(reg_row(rps_pkg::REG_COND_TIME, 16'd0));
		script.push_back(cmd_row(rps_pkg::CMD_START, 16'd0, 1'b0, 1'b0));
		script.push_back(reg_row(rps_pkg::REG_TOTAL_REPEATS, 16'h00FF));
		script.push_back(reg_row(rps_pkg::REG_CONDITION_MODE, {14'd0, rps_pkg::CMODE_TEMP}));
		script.push_back(reg_row(rps_pkg::REG_COND_TIME, 16'hFFFF));
		script.push_back(reg_row(rps_pkg::REG_TARGET_TEMP, 16'h8000));
		script.push_back(cmd_row(rps_pkg::CMD_START, 16'd0, 1'b0, 1'b0));
		script.push_back(cmd_row(rps_pkg::CMD_TICK, 16'h8000, 1'b1, 1'b0));
		script.push_back(reg_row(rps_pkg::REG_EXEC_TIME, 16'hFFFF));
		script.push_back(cmd_row(rps_pkg::CMD_TICK, 16'h8000, 1'b1, 1'b0));

		foreach (script[i]) begin
			if (script[i].wr) write_reg(script[i].idx, script[i].data);
			else issue(script[i].c, script[i].typed, script[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0) begin
				// Longest run with instant repeats drives the repeat index to its top.
				tr = 8'hFF; cm = rps_pkg::CMODE_NONE; ct = 16'hFFFF; tt = 16'h7FFF; et = 16'd0;
			end else if (p == 1) begin
				tr = 8'hFF; cm = rps_pkg::CMODE_TEMP; ct = 16'hFFFF; tt = 16'h8000; et = 16'hFFFF;
			end else begin
				tr = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
				cm = 2'($urandom_range(0, 3));
				ct = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
				tt = 16'($urandom);
				et = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
			end
			junk = 16'($urandom);
			write_reg(rps_pkg::REG_TOTAL_REPEATS, {junk[15:8], tr});
			write_reg(rps_pkg::REG_CONDITION_MODE, {junk[13:0], cm});
			write_reg(rps_pkg::REG_COND_TIME, ct);
			write_reg(rps_pkg::REG_TARGET_TEMP, tt);
			write_reg(rps_pkg::REG_EXEC_TIME, et);
			n_items = (p == 0) ? 600 : 200;
			if (p == 0 || $urandom_range(0, 1) == 1) begin
				c = '0;
				c.mode = rps_pkg::CMD_START;
				c.temperature = 16'($urandom);
				issue(c, 1'b0, '0);
			end
			for (int k = 0; k < n_items; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 4) c.mode = rps_pkg::CMD_PAUSE;
				else if (pick < 14) c.mode = rps_pkg::CMD_RESUME;
				else if (pick < 20 && p != 0) c.mode = rps_pkg::CMD_START;
				else c.mode = rps_pkg::CMD_TICK;
				near = 16'(regs.target_temperature + $urandom_range(0, 6) - 3);
				c.temperature = $urandom_range(0, 1) ? near : 16'($urandom);
				c.temp_sensor_present = ($urandom_range(0, 3) != 0);
				c.pressure_violation = ($urandom_range(0, 11) == 0);
				issue(c, 1'b0, '0);
				if ($urandom_range(0, 149) == 0) drain();
			end
		end

		drain();
		repeat (8) @(negedge clk);
		if (errors == 0) begin
			$display("tb_repeat_phase_sequencer OK");
		end else begin
			$display("tb_repeat_phase_sequencer NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire
